// File: rtl/uvst_pkg.sv
// uvst_pkg: request, status and sequencer state types for the unique value set table
`timescale 1ns / 1ps

package uvst_pkg;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_POP    = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_RANGE    = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_FINISH
  } state_t;

endpackage

// File: rtl/uvst_ram.sv
// uvst_ram: generic single write, single read port ram with registered read data
`timescale 1ns / 1ps

module uvst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/unique_value_set_table_top.sv
// unique_value_set_table_top: ram-backed set of distinct signed words with scan sequencer
//
//   channel | direction | ports                                          | handshake
//   --------+-----------+------------------------------------------------+----------------
//   request | in        | in_req_type, in_value, in_position             | in_valid/in_ready
//   result  | out       | out_read_value, out_entry_count, out_status    | out_valid/out_ready
//
// sequence: add and remove go through accept, a scan of the single read port ram
//   over the stored entries with registered read data, and finish; an add that
//   hits a duplicate stops early; read adds a ram read state, pop goes straight to finish
// reset: clears the entry count, the handshake state and the compare valid flag
//   only; entries beyond the count are never read, so the ram needs no clearing pass
// stalls: a new word is taken while the last result still waits in the output
//   register; the finish cycle holds until that register is free
`timescale 1ns / 1ps

module unique_value_set_table_top
  import uvst_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic signed [31:0] in_value,
  input  logic [3:0]         in_position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_read_value,
  output logic [4:0]         out_entry_count,
  output logic [2:0]         out_status
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // sequencer state
  state_t             state_r, state_nxt;
  req_t               req_r, req_nxt;
  logic [31:0]        val_r, val_nxt;
  logic [3:0]         pos_r, pos_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  // scan pipeline: read issue index and the index whose data is on the ram output
  logic [CNT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic               found_r, found_nxt;
  logic               rdok_r, rdok_nxt;
  logic               hit;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_rv_r, out_rv_nxt;
  logic [4:0]         out_cnt_r, out_cnt_nxt;
  status_t            out_st_r, out_st_nxt;

  // ram ports
  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [31:0]        ram_wdata, ram_rdata;

  uvst_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // comparator on the word just read back
  assign hit = cmp_vld_r && (ram_rdata == val_r);

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_read_value  = out_rv_r;
  assign out_entry_count = out_cnt_r;
  assign out_status      = out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    val_r     <= val_nxt;
    pos_r     <= pos_nxt;
    rd_idx_r  <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    found_r   <= found_nxt;
    rdok_r    <= rdok_nxt;
    out_rv_r  <= out_rv_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_st_r  <= out_st_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    val_nxt       = val_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_idx_nxt   = cmp_idx_r;
    found_nxt     = found_r;
    rdok_nxt      = rdok_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_rv_nxt    = out_rv_r;
    out_cnt_nxt   = out_cnt_r;
    out_st_nxt    = out_st_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt     = req_t'(in_req_type);
          val_nxt     = in_value;
          pos_nxt     = in_position;
          rd_idx_nxt  = '0;
          cmp_vld_nxt = 1'b0;
          found_nxt   = 1'b0;
          rdok_nxt    = 1'b0;
          unique case (req_t'(in_req_type)) inside
            REQ_ADD, REQ_REMOVE: state_nxt = S_SCAN;
            REQ_READ:            state_nxt = S_READ;
            default:             state_nxt = S_FINISH;
          endcase
        end
      end

      S_SCAN: begin
        // remove: once the match is seen, every later word moves down one place
        if (cmp_vld_r && (req_r == REQ_REMOVE)) begin
          if (found_r) begin
            ram_we    = 1'b1;
            ram_waddr = cmp_idx_r - IDX_W'(1);
            ram_wdata = ram_rdata;
          end else if (hit) begin
            found_nxt = 1'b1;
          end
        end
        if ((req_r == REQ_ADD) && hit) begin
          // duplicate found, no need to look further
          found_nxt   = 1'b1;
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_FINISH;
        end else if (rd_idx_r < count_r) begin
          ram_re      = 1'b1;
          ram_raddr   = rd_idx_r[IDX_W-1:0];
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt  = rd_idx_r + CNT_W'(1);
        end else begin
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_FINISH;
        end
      end

      S_READ: begin
        if (32'(pos_r) < 32'(count_r)) begin
          ram_re    = 1'b1;
          ram_raddr = IDX_W'(pos_r);
          rdok_nxt  = 1'b1;
        end
        state_nxt = S_FINISH;
      end

      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_rv_nxt    = '0;
          out_cnt_nxt   = 5'(32'(count_r));
          out_st_nxt    = ST_OK;
          state_nxt     = S_IDLE;
          unique case (req_r)
            REQ_ADD: begin
              if (found_r) begin
                out_st_nxt = ST_DUP;
              end else if (32'(count_r) >= CAPACITY) begin
                out_st_nxt = ST_FULL;
              end else begin
                ram_we      = 1'b1;
                ram_waddr   = count_r[IDX_W-1:0];
                ram_wdata   = val_r;
                count_nxt   = count_r + CNT_W'(1);
                out_cnt_nxt = 5'(32'(count_r) + 32'd1);
              end
            end
            REQ_REMOVE: begin
              if (found_r) begin
                count_nxt   = count_r - CNT_W'(1);
                out_cnt_nxt = 5'(32'(count_r) - 32'd1);
              end else begin
                out_st_nxt = ST_NOTFOUND;
              end
            end
            REQ_READ: begin
              if (rdok_r) begin
                out_rv_nxt = ram_rdata;
              end else begin
                out_st_nxt = ST_RANGE;
              end
            end
            default: begin
              if (count_r == '0) begin
                out_st_nxt = ST_EMPTY;
              end else begin
                count_nxt   = count_r - CNT_W'(1);
                out_cnt_nxt = 5'(32'(count_r) - 32'd1);
              end
            end
          endcase
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: rtl/uvst_checker.sv
// uvst_checker: port-level assertions for the unique value set table, bound to the top level
`timescale 1ns / 1ps

module uvst_checker
  import uvst_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         in_req_type,
  input logic signed [31:0] in_value,
  input logic [3:0]         in_position,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_read_value,
  input logic [4:0]         out_entry_count,
  input logic [2:0]         out_status
);

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CAPACITY > 31) || (32'(out_entry_count) <= CAPACITY))
    else $error("entry count above capacity");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_EMPTY)) |-> (out_entry_count == 5'd0))
    else $error("empty status with non-zero count");

  a_rv_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_read_value != 32'sd0)) |-> (out_status == ST_OK))
    else $error("read data on a failed or non-read word");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_read_value)
      && $stable(out_entry_count) && $stable(out_status)))
    else $error("result word changed while stalled");

endmodule

bind unique_value_set_table_top uvst_checker #(.CAPACITY(CAPACITY)) u_uvst_checker (.*);
